// ===== rtl/core/sgcw_pkg.sv =====
// Shared types, constants and divider step for the segment grid cell walker.
`default_nettype none
package sgcw_pkg;

   localparam int MAX_CELLS = 64;
   localparam int CNT_W     = $clog2(MAX_CELLS);
   localparam int ACC_W     = 64 + CNT_W;

   localparam logic [1:0]  CSR_CELL_WIDTH  = 2'd0;
   localparam logic [1:0]  CSR_CELL_HEIGHT = 2'd1;
   localparam logic [30:0] CELL_SIZE_RESET = 31'd1000000;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] cell_col;
      logic signed [31:0] cell_row;
      logic               last_cell;
      logic               truncated;
   } rsp_type;

   // Walk plan handed from the setup side to the walker
   typedef struct packed {
      logic signed [31:0] col;
      logic signed [31:0] row;
      logic signed [31:0] ecol;
      logic signed [31:0] erow;
      logic               x_neg;
      logic               y_neg;
      logic [63:0]        px;
      logic [63:0]        py;
      logic [63:0]        kx;
      logic [63:0]        ky;
   } plan_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] quo;
   } div_type;

   // One restoring division step: shift in the next dividend bit
   function automatic div_type div_step(div_type s, logic [30:0] d);
      logic [32:0] t;
      div_type     r;
      t = {s.rem, s.quo[31]};
      if (t >= {2'b00, d}) begin
         r.rem = 32'(t - {2'b00, d});
         r.quo = {s.quo[30:0], 1'b1};
      end else begin
         r.rem = t[31:0];
         r.quo = {s.quo[30:0], 1'b0};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sgcw_front.sv =====
// Setup side: accepts segments, finds cell indices and crossing terms.
`default_nettype none
module sgcw_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire sgcw_pkg::req_type req_data,
   input  wire logic [30:0]      cell_width,
   input  wire logic [30:0]      cell_height,
   output logic                  plan_push,
   output sgcw_pkg::plan_type    plan,
   input  wire logic             plan_full
);
   import sgcw_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_FIX, ST_MUL, ST_PUSH} state_type;

   state_type      state_ff;
   logic [30:0]    cw_ff, ch_ff;
   div_type        div_ff [4];
   logic [3:0]     neg_ff;
   logic [4:0]     step_ff;
   logic [31:0]    adx_ff, ady_ff;
   logic [30:0]    numx_ff, numy_ff;
   logic [1:0]     mul_idx_ff;
   plan_type       plan_ff;

   logic [30:0]        lane_d [4];
   logic signed [31:0] lane_q [4];
   logic [30:0]        lane_r [4];
   logic [32:0]        dx_in, dy_in;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;

   assign req_full  = (state_ff != ST_IDLE);
   assign plan_push = (state_ff == ST_PUSH) && !plan_full;
   assign plan      = plan_ff;

   assign dx_in = {req_data.end_x[31], req_data.end_x} - {req_data.start_x[31], req_data.start_x};
   assign dy_in = {req_data.end_y[31], req_data.end_y} - {req_data.start_y[31], req_data.start_y};

   // Floor correction of each lane's magnitude quotient
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lane_d[i] = (i % 2 == 1) ? ch_ff : cw_ff;
         if (!neg_ff[i]) begin
            lane_q[i] = div_ff[i].quo;
            lane_r[i] = div_ff[i].rem[30:0];
         end else if (div_ff[i].rem[30:0] == 31'd0) begin
            lane_q[i] = -div_ff[i].quo;
            lane_r[i] = 31'd0;
         end else begin
            lane_q[i] = ~div_ff[i].quo;
            lane_r[i] = lane_d[i] - div_ff[i].rem[30:0];
         end
      end
   end

   // Shared multiplier operand select
   always_comb begin
      case (mul_idx_ff)
         2'd0:    begin mul_a = {1'b0, numx_ff}; mul_b = ady_ff; end
         2'd1:    begin mul_a = {1'b0, numy_ff}; mul_b = adx_ff; end
         2'd2:    begin mul_a = {1'b0, cw_ff};   mul_b = ady_ff; end
         default: begin mul_a = {1'b0, ch_ff};   mul_b = adx_ff; end
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_push) begin
                  cw_ff   <= (cell_width  == 31'd0) ? 31'd1 : cell_width;
                  ch_ff   <= (cell_height == 31'd0) ? 31'd1 : cell_height;
                  neg_ff  <= {req_data.end_y[31], req_data.end_x[31],
                              req_data.start_y[31], req_data.start_x[31]};
                  div_ff[0] <= '{rem: 32'd0, quo: req_data.start_x[31] ?
                                 32'(-req_data.start_x) : req_data.start_x};
                  div_ff[1] <= '{rem: 32'd0, quo: req_data.start_y[31] ?
                                 32'(-req_data.start_y) : req_data.start_y};
                  div_ff[2] <= '{rem: 32'd0, quo: req_data.end_x[31] ?
                                 32'(-req_data.end_x) : req_data.end_x};
                  div_ff[3] <= '{rem: 32'd0, quo: req_data.end_y[31] ?
                                 32'(-req_data.end_y) : req_data.end_y};
                  plan_ff.x_neg <= dx_in[32];
                  plan_ff.y_neg <= dy_in[32];
                  adx_ff  <= dx_in[32] ? 32'(-dx_in) : dx_in[31:0];
                  ady_ff  <= dy_in[32] ? 32'(-dy_in) : dy_in[31:0];
                  step_ff <= 5'd0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               // advance all four dividers by one bit
               for (int i = 0; i < 4; i++) begin
                  div_ff[i] <= div_step(div_ff[i], lane_d[i]);
               end
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd31) begin
                  state_ff <= ST_FIX;
               end
            end
            ST_FIX: begin
               plan_ff.col  <= lane_q[0];
               plan_ff.row  <= lane_q[1];
               plan_ff.ecol <= lane_q[2];
               plan_ff.erow <= lane_q[3];
               numx_ff <= plan_ff.x_neg ? lane_r[0] : cw_ff - lane_r[0];
               numy_ff <= plan_ff.y_neg ? lane_r[1] : ch_ff - lane_r[1];
               mul_idx_ff <= 2'd0;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               case (mul_idx_ff)
                  2'd0:    plan_ff.px <= mul_p;
                  2'd1:    plan_ff.py <= mul_p;
                  2'd2:    plan_ff.kx <= mul_p;
                  default: plan_ff.ky <= mul_p;
               endcase
               mul_idx_ff <= mul_idx_ff + 2'd1;
               if (mul_idx_ff == 2'd3) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (!plan_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/sgcw_back.sv =====
// Walk side: plan queue, cell stepping and result queue.
`default_nettype none
module sgcw_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              plan_push,
   input  wire sgcw_pkg::plan_type plan_in,
   output logic                   plan_full,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output sgcw_pkg::rsp_type      rsp_data
);
   import sgcw_pkg::*;

   typedef enum logic {ST_IDLE, ST_WALK} state_type;

   plan_type           pq_mem_ff [2];
   logic               pq_wr_ff, pq_rd_ff;
   logic [1:0]         pq_cnt_ff;
   rsp_type            oq_mem_ff [2];
   logic               oq_wr_ff, oq_rd_ff;
   logic [1:0]         oq_cnt_ff;

   state_type          state_ff;
   logic signed [31:0] col_ff, row_ff, ecol_ff, erow_ff;
   logic               xneg_ff, yneg_ff;
   logic [ACC_W-1:0]   px_ff, py_ff;
   logic [63:0]        kx_ff, ky_ff;
   logic [CNT_W-1:0]   n_ff;

   logic pq_pop, oq_pop, emit, at_end, at_limit, fin;
   rsp_type visit;

   assign plan_full = (pq_cnt_ff == 2'd2);
   assign pq_pop    = (state_ff == ST_IDLE) && (pq_cnt_ff != 2'd0);
   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign rsp_data  = oq_mem_ff[oq_rd_ff];
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign emit      = (state_ff == ST_WALK) && (oq_cnt_ff != 2'd2);
   assign at_end    = (col_ff == ecol_ff) && (row_ff == erow_ff);
   assign at_limit  = (n_ff == CNT_W'(MAX_CELLS - 1));
   assign fin       = at_end || at_limit;

   always_comb begin
      visit.cell_col  = col_ff;
      visit.cell_row  = row_ff;
      visit.last_cell = fin;
      visit.truncated = at_limit && !at_end;
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (plan_push && !plan_full) begin
         pq_mem_ff[pq_wr_ff] <= plan_in;
      end
      if (emit) begin
         oq_mem_ff[oq_wr_ff] <= visit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pq_wr_ff  <= 1'b0;
         pq_rd_ff  <= 1'b0;
         pq_cnt_ff <= 2'd0;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
         state_ff  <= ST_IDLE;
      end else begin
         // plan queue pointers
         if (plan_push && !plan_full) pq_wr_ff <= ~pq_wr_ff;
         if (pq_pop) pq_rd_ff <= ~pq_rd_ff;
         pq_cnt_ff <= pq_cnt_ff + 2'(plan_push && !plan_full) - 2'(pq_pop);
         // result queue pointers
         if (emit) oq_wr_ff <= ~oq_wr_ff;
         if (oq_pop) oq_rd_ff <= ~oq_rd_ff;
         oq_cnt_ff <= oq_cnt_ff + 2'(emit) - 2'(oq_pop);

         case (state_ff)
            ST_IDLE: begin
               if (pq_pop) begin
                  col_ff  <= pq_mem_ff[pq_rd_ff].col;
                  row_ff  <= pq_mem_ff[pq_rd_ff].row;
                  ecol_ff <= pq_mem_ff[pq_rd_ff].ecol;
                  erow_ff <= pq_mem_ff[pq_rd_ff].erow;
                  xneg_ff <= pq_mem_ff[pq_rd_ff].x_neg;
                  yneg_ff <= pq_mem_ff[pq_rd_ff].y_neg;
                  px_ff   <= ACC_W'(pq_mem_ff[pq_rd_ff].px);
                  py_ff   <= ACC_W'(pq_mem_ff[pq_rd_ff].py);
                  kx_ff   <= pq_mem_ff[pq_rd_ff].kx;
                  ky_ff   <= pq_mem_ff[pq_rd_ff].ky;
                  n_ff    <= '0;
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               if (emit) begin
                  if (fin) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     n_ff <= n_ff + CNT_W'(1);
                     // step x when its crossing comes strictly first
                     if (col_ff == ecol_ff) begin
                        row_ff <= yneg_ff ? row_ff - 32'sd1 : row_ff + 32'sd1;
                     end else if (row_ff == erow_ff) begin
                        col_ff <= xneg_ff ? col_ff - 32'sd1 : col_ff + 32'sd1;
                     end else if (px_ff < py_ff) begin
                        col_ff <= xneg_ff ? col_ff - 32'sd1 : col_ff + 32'sd1;
                        px_ff  <= px_ff + ACC_W'(kx_ff);
                     end else begin
                        row_ff <= yneg_ff ? row_ff - 32'sd1 : row_ff + 32'sd1;
                        py_ff  <= py_ff + ACC_W'(ky_ff);
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/segment_grid_cell_walker_core.sv =====
// Top level: cell size registers, setup side and walk side.
// Setup runs each segment through the four bit-serial floor dividers, then the
// floor fix-up, then four products on the shared 32x32 multiplier, then a hand-off.
// The walker then emits one cell per cycle while the result queue has room.
// A two-entry plan queue lets setup overlap walking.
// Synchronous reset empties both queues and sets both cell sizes to 1000000.
`default_nettype none
module segment_grid_cell_walker_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire sgcw_pkg::req_type req_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output sgcw_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_en,
   input  wire logic [1:0]        csr_index,
   input  wire logic [30:0]       csr_wdata
);
   import sgcw_pkg::*;

   logic [30:0] cw_ff, ch_ff;
   logic        plan_push, plan_full;
   plan_type    plan;

   // Cell size registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff <= CELL_SIZE_RESET;
         ch_ff <= CELL_SIZE_RESET;
      end else if (csr_write_en) begin
         if (csr_index == CSR_CELL_WIDTH)  cw_ff <= csr_wdata;
         if (csr_index == CSR_CELL_HEIGHT) ch_ff <= csr_wdata;
      end
   end

   sgcw_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .cell_width (cw_ff), .cell_height (ch_ff),
      .plan_push, .plan, .plan_full
   );

   sgcw_back u_back (
      .clock, .reset, .plan_push, .plan_in (plan), .plan_full,
      .rsp_pop, .rsp_empty, .rsp_data
   );
endmodule
`default_nettype wire

// ===== rtl/core/sgcw_checker.sv =====
// Port-level checker for the cell walker, bound to the top level.
`default_nettype none
module sgcw_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_push,
   input wire logic              req_full,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire sgcw_pkg::rsp_type rsp_data
);
   import sgcw_pkg::*;

   // reset leaves both sides open and empty
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not clear after reset");

   // truncation only marks the final cell
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (!rsp_data.truncated || rsp_data.last_cell))
      else $error("truncated set on a non-final cell");

   // an accepted segment occupies setup
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("setup not busy after transfer");

   // a waiting result holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result changed while stalled");
endmodule

bind segment_grid_cell_walker_core sgcw_checker u_sgcw_checker (
   .clock, .reset, .req_push, .req_full, .rsp_empty, .rsp_pop, .rsp_data
);
`default_nettype wire
